FILE: sv/peak_hold_rms_level_meter_macros.svh
// Assertion macros for the peak hold RMS level meter.
// Included by the top level; no other dependencies.
`ifndef PEAK_HOLD_RMS_LEVEL_METER_MACROS_SVH
`define PEAK_HOLD_RMS_LEVEL_METER_MACROS_SVH
`ifndef SYNTHESIS
`define PHM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("level meter check failed");
`define PHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("level meter check failed");
`else
`define PHM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PHM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/phm_pkg.sv
// Shared types and constants of the peak hold RMS level meter.
// No dependencies.
package phm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MS_SHIFT    = 64 - 2 * SAMPLE_BITS;
  localparam int LG_W        = 24;
  localparam int NORM_STEPS  = 6;
  localparam int LOG_BITS    = 16;
  localparam int OUT_W       = 13;

  localparam logic [31:0] DECAY_Q24 = 32'd16775538;
  localparam logic [31:0] DB_K_Q16  = 32'd3156528;
  localparam logic signed [13:0] DB_FLOOR = -14'sd3200;

  localparam logic [19:0] HOLD_RST     = 20'd96000;
  localparam logic [31:0] ALPHA_RST    = 32'd715756;
  localparam logic [15:0] INTERVAL_RST = 16'd6000;
  localparam logic [11:0] CAL_RST      = 12'd2032;

  localparam logic [2:0] REG_HOLD     = 3'd0;
  localparam logic [2:0] REG_ALPHA    = 3'd1;
  localparam logic [2:0] REG_INTERVAL = 3'd2;
  localparam logic [2:0] REG_CAL      = 3'd3;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SQ    = 14'b00000000000010,
    S_DIFF  = 14'b00000000000100,
    S_HI    = 14'b00000000001000,
    S_LO    = 14'b00000000010000,
    S_STEP  = 14'b00000000100000,
    S_MS    = 14'b00000001000000,
    S_PKSQ  = 14'b00000010000000,
    S_QLD   = 14'b00000100000000,
    S_NORM  = 14'b00001000000000,
    S_LOG   = 14'b00010000000000,
    S_SCALE = 14'b00100000000000,
    S_RND   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  typedef struct packed {
    state_t     op;
    logic       load;
    logic       rms_sel;
    logic [3:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic report;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: sv/phm_ctrl.sv
// Sequencer of the level meter: steps the datapath through one word.
// Depends on phm_pkg.
module phm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  phm_pkg::dp_stat_t stat,
  output phm_pkg::dp_cmd_t  cmd
);

  phm_pkg::state_t state_r, state_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            rms_sel_r, rms_sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= phm_pkg::S_IDLE;
      cnt_r     <= '0;
      rms_sel_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rms_sel_r <= rms_sel_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rms_sel_nxt = rms_sel_r;
    case (state_r)
      phm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = phm_pkg::S_SQ;
      end
      phm_pkg::S_SQ:   state_nxt = phm_pkg::S_DIFF;
      phm_pkg::S_DIFF: state_nxt = phm_pkg::S_HI;
      phm_pkg::S_HI:   state_nxt = phm_pkg::S_LO;
      phm_pkg::S_LO:   state_nxt = phm_pkg::S_STEP;
      phm_pkg::S_STEP: state_nxt = phm_pkg::S_MS;
      phm_pkg::S_MS: begin
        rms_sel_nxt = 1'b0;
        state_nxt   = stat.report ? phm_pkg::S_PKSQ : phm_pkg::S_IDLE;
      end
      phm_pkg::S_PKSQ: state_nxt = phm_pkg::S_QLD;
      phm_pkg::S_QLD: begin
        cnt_nxt   = 4'(phm_pkg::NORM_STEPS - 1);
        state_nxt = phm_pkg::S_NORM;
      end
      phm_pkg::S_NORM: begin
        if (cnt_r == '0) begin
          cnt_nxt   = 4'(phm_pkg::LOG_BITS - 1);
          state_nxt = phm_pkg::S_LOG;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      phm_pkg::S_LOG: begin
        if (cnt_r == '0) state_nxt = phm_pkg::S_SCALE;
        else cnt_nxt = cnt_r - 4'd1;
      end
      phm_pkg::S_SCALE: state_nxt = phm_pkg::S_RND;
      phm_pkg::S_RND: begin
        if (rms_sel_r) begin
          state_nxt = phm_pkg::S_OUT;
        end else begin
          rms_sel_nxt = 1'b1;
          state_nxt   = phm_pkg::S_QLD;
        end
      end
      phm_pkg::S_OUT: begin
        if (!stat.out_busy) state_nxt = phm_pkg::S_IDLE;
      end
      default: state_nxt = phm_pkg::S_IDLE;
    endcase
  end

  assign in_ready    = (state_r == phm_pkg::S_IDLE);
  assign cmd.op      = state_r;
  assign cmd.load    = in_valid && in_ready;
  assign cmd.rms_sel = rms_sel_r;
  assign cmd.idx     = cnt_r;

endmodule

FILE: sv/phm_dp.sv
// Datapath of the level meter: registers, shared multiplier, peak, mean square,
// log2 and dB scaling, output register. Depends on phm_pkg.
module phm_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  phm_pkg::dp_cmd_t                       cmd,
  output phm_pkg::dp_stat_t                      stat,
  input  logic signed [phm_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   cfg_we,
  input  logic [2:0]                             cfg_index,
  input  logic [31:0]                            cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [phm_pkg::OUT_W-1:0]       out_peak_db,
  output logic signed [phm_pkg::OUT_W-1:0]       out_rms_db
);

  localparam int SB = phm_pkg::SAMPLE_BITS;
  localparam int LW = phm_pkg::LG_W;

  logic [19:0] hold_samples_r;
  logic [31:0] alpha_r;
  logic [15:0] interval_r;
  logic [11:0] cal_r;

  logic [SB-1:0] mag_r, peak_r;
  logic [19:0]   hold_r;
  logic [63:0]   ms_r;
  logic [15:0]   icnt_r;
  logic [63:0]   prod_r, d_r, acc_r, step_r, q_r;
  logic          neg_r;
  logic [5:0]    sh_r;
  logic signed [LW-1:0] lg_r;
  logic [31:0]   m_r;
  logic signed [phm_pkg::OUT_W-1:0] pk_db_r, rms_db_r, out_pk_r, out_rms_r;
  logic          out_valid_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [SB-1:0] mag_in;
  logic [63:0] sq, pksq;
  logic [15:0] icnt_inc;
  logic [63:0] q_n;
  logic [5:0]  sh_n;
  logic [LW-1:0] lg_abs;
  logic [63:0] rnd_sum;
  logic signed [13:0] lvl;
  logic signed [13:0] db;

  assign mag_in = in_sample[SB-1] ? SB'(-in_sample) : SB'(in_sample);
  assign sq     = 64'(prod_r[2*SB-1:0]) << phm_pkg::MS_SHIFT;
  assign pksq   = sq;
  assign icnt_inc = icnt_r + 16'd1;
  assign lg_abs = lg_r[LW-1] ? LW'(-lg_r) : LW'(lg_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      phm_pkg::S_SQ:    begin mul_a = 32'(mag_r);  mul_b = 32'(mag_r); end
      phm_pkg::S_DIFF:  begin mul_a = 32'(peak_r); mul_b = phm_pkg::DECAY_Q24; end
      phm_pkg::S_HI:    begin mul_a = d_r[63:32];  mul_b = alpha_r; end
      phm_pkg::S_LO:    begin mul_a = d_r[31:0];   mul_b = alpha_r; end
      phm_pkg::S_PKSQ:  begin mul_a = 32'(peak_r); mul_b = 32'(peak_r); end
      phm_pkg::S_LOG:   begin mul_a = m_r;         mul_b = m_r; end
      phm_pkg::S_SCALE: begin mul_a = 32'(lg_abs); mul_b = phm_pkg::DB_K_Q16; end
      default:          begin mul_a = '0;          mul_b = '0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    q_n  = q_r;
    sh_n = sh_r;
    case (cmd.idx)
      4'd5: if (q_r[63:32] == '0) begin q_n = q_r << 32; sh_n = sh_r + 6'd32; end
      4'd4: if (q_r[63:48] == '0) begin q_n = q_r << 16; sh_n = sh_r + 6'd16; end
      4'd3: if (q_r[63:56] == '0) begin q_n = q_r << 8;  sh_n = sh_r + 6'd8;  end
      4'd2: if (q_r[63:60] == '0) begin q_n = q_r << 4;  sh_n = sh_r + 6'd4;  end
      4'd1: if (q_r[63:62] == '0) begin q_n = q_r << 2;  sh_n = sh_r + 6'd2;  end
      4'd0: if (q_r[63] == 1'b0)  begin q_n = q_r << 1;  sh_n = sh_r + 6'd1;  end
      default: begin q_n = q_r; sh_n = sh_r; end
    endcase
  end

  assign rnd_sum = prod_r + 64'h0000_0000_8000_0000;

  always_comb begin
    if (!q_r[63]) lvl = phm_pkg::DB_FLOOR;
    else if (lg_r[LW-1]) lvl = -$signed({1'b0, rnd_sum[44:32]});
    else lvl = $signed({1'b0, rnd_sum[44:32]});
    db = lvl + $signed({2'b00, cal_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_samples_r <= phm_pkg::HOLD_RST;
      alpha_r        <= phm_pkg::ALPHA_RST;
      interval_r     <= phm_pkg::INTERVAL_RST;
      cal_r          <= phm_pkg::CAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        phm_pkg::REG_HOLD:     hold_samples_r <= cfg_data[19:0];
        phm_pkg::REG_ALPHA:    alpha_r        <= cfg_data;
        phm_pkg::REG_INTERVAL: interval_r     <= cfg_data[15:0];
        phm_pkg::REG_CAL:      cal_r          <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= '0;
      hold_r      <= '0;
      ms_r        <= '0;
      icnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == phm_pkg::S_HI) begin
        if (mag_r >= peak_r) begin
          peak_r <= mag_r;
          hold_r <= hold_samples_r;
        end else if (hold_r != '0) begin
          hold_r <= hold_r - 20'd1;
        end else begin
          peak_r <= prod_r[24 +: SB];
        end
      end
      if (cmd.op == phm_pkg::S_MS) begin
        ms_r   <= neg_r ? ms_r - step_r : ms_r + step_r;
        icnt_r <= stat.report ? '0 : icnt_inc;
      end
      if (cmd.op == phm_pkg::S_OUT && !stat.out_busy) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mag_r <= mag_in;
    prod_r <= prod;
    if (cmd.op == phm_pkg::S_DIFF) begin
      neg_r <= sq < ms_r;
      d_r   <= (sq < ms_r) ? ms_r - sq : sq - ms_r;
    end
    if (cmd.op == phm_pkg::S_LO) acc_r <= prod_r;
    if (cmd.op == phm_pkg::S_STEP) step_r <= acc_r + {32'b0, prod_r[63:32]};
    if (cmd.op == phm_pkg::S_QLD) begin
      q_r  <= cmd.rms_sel ? ms_r : pksq;
      sh_r <= '0;
    end
    if (cmd.op == phm_pkg::S_NORM) begin
      q_r  <= q_n;
      sh_r <= sh_n;
      if (cmd.idx == '0) begin
        lg_r <= (LW'(1) - LW'(sh_n)) <<< 16;
        m_r  <= q_n[63:32];
      end
    end
    if (cmd.op == phm_pkg::S_LOG) begin
      if (prod[63]) begin
        lg_r <= lg_r + (LW'(1) << cmd.idx);
        m_r  <= prod[63:32];
      end else begin
        m_r  <= prod[62:31];
      end
    end
    if (cmd.op == phm_pkg::S_RND) begin
      if (cmd.rms_sel) rms_db_r <= db[phm_pkg::OUT_W-1:0];
      else pk_db_r <= db[phm_pkg::OUT_W-1:0];
    end
    if (cmd.op == phm_pkg::S_OUT && !stat.out_busy) begin
      out_pk_r  <= pk_db_r;
      out_rms_r <= rms_db_r;
    end
  end

  assign stat.report   = (icnt_inc >= interval_r);
  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_peak_db   = out_pk_r;
  assign out_rms_db    = out_rms_r;

endmodule

FILE: sv/peak_hold_rms_level_meter.sv
// Peak hold and RMS level meter, top level. A word steps through square, difference,
// high and low product, step and mean square; a report adds a peak square, 2 passes of
// load, normalize (6), log2 (16, one bit per cycle on the shared 32x32 multiplier),
// scale and round, and the output load, which waits for the previous word to be taken.
// Synchronous active-low reset clears peak, hold, mean square, interval count and
// output valid, and restores register defaults. Depends on phm_pkg, phm_ctrl, phm_dp.
`include "peak_hold_rms_level_meter_macros.svh"
module peak_hold_rms_level_meter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [phm_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [phm_pkg::OUT_W-1:0]       out_peak_db,
  output logic signed [phm_pkg::OUT_W-1:0]       out_rms_db,
  input  logic                                   cfg_we,
  input  logic [2:0]                             cfg_index,
  input  logic [31:0]                            cfg_data
);

  phm_pkg::dp_cmd_t  cmd;
  phm_pkg::dp_stat_t stat;

  phm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  phm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_sample   (in_sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_peak_db (out_peak_db),
    .out_rms_db  (out_rms_db)
  );

  `PHM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `PHM_ASSERT_NEXT(a_no_early_word, clk, rst_n, in_valid && in_ready, !$rose(out_valid))
  `PHM_ASSERT_NOW(a_word_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule
